// ----- rtl/core/dda_line_rasterizer_defines.svh -----
// Assertion macros for the checker file.
`ifndef DDA_LINE_RASTERIZER_DEFINES_SVH
`define DDA_LINE_RASTERIZER_DEFINES_SVH

// same-cycle implication
`define DLR_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

// next-cycle implication
`define DLR_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) else $error(msg);

`endif

// ----- rtl/core/dlr_pkg.sv -----
package dlr_pkg;

   localparam int COORD_W      = 6;
   localparam int GRAY_W       = 8;
   localparam int ADDR_OUT_W   = 12;
   localparam int STRIDE_W     = 7;
   localparam int POS_W        = 16;   // signed row base / column / address
   localparam int FRAC_W       = 16;   // Q.16 slope
   localparam int QUO_W        = FRAC_W + 1;
   localparam int ACC_W        = 22;
   localparam int DIV_STEPS    = QUO_W;
   localparam int DIV_CNT_W    = $clog2(DIV_STEPS);
   localparam int IMAGE_SIDE_DEF = 64;

   localparam logic [STRIDE_W-1:0] STRIDE_RESET = 7'd64;

   localparam int CSR_ADDR_W = 3;
   localparam int CSR_DATA_W = 32;
   // register index, taken from the word-address bit of paddr
   localparam logic CSR_ROW_STRIDE = 1'b0;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_DIVIDE,
      ST_WALK,
      ST_FLUSH
   } state_type;

   typedef struct packed {
      logic load;
      logic div_step;
      logic div_first;
      logic walk_step;
      logic flush;
   } dp_cmd_type;

   typedef struct packed {
      logic zero_len;
      logic walk_last;
      logic can_push;
   } dp_status_type;

endpackage

// ----- rtl/core/dlr_controller.sv -----
module dlr_controller (
   input  logic                   clock,
   input  logic                   reset,
   input  logic                   req_valid,
   output logic                   req_ready,
   input  dlr_pkg::dp_status_type status,
   output dlr_pkg::dp_cmd_type    cmd
);

   dlr_pkg::state_type state_ff, state_in;
   logic [dlr_pkg::DIV_CNT_W-1:0] div_cnt_ff, div_cnt_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= dlr_pkg::ST_IDLE;
         div_cnt_ff <= '0;
      end else begin
         state_ff   <= state_in;
         div_cnt_ff <= div_cnt_in;
      end
   end

   always_comb begin
      state_in   = state_ff;
      div_cnt_in = div_cnt_ff;
      cmd        = '0;
      req_ready  = 1'b0;
      case (state_ff)
         dlr_pkg::ST_IDLE: begin
            req_ready  = 1'b1;
            div_cnt_in = '0;
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = dlr_pkg::ST_DIVIDE;
            end
         end
         dlr_pkg::ST_DIVIDE: begin
            if (status.zero_len) begin
               state_in = dlr_pkg::ST_IDLE;
            end else begin
               cmd.div_step  = 1'b1;
               cmd.div_first = (div_cnt_ff == '0);
               div_cnt_in    = div_cnt_ff + 1'b1;
               if (div_cnt_ff == dlr_pkg::DIV_CNT_W'(dlr_pkg::DIV_STEPS - 1)) begin
                  state_in = dlr_pkg::ST_WALK;
               end
            end
         end
         dlr_pkg::ST_WALK: begin
            if (status.can_push) begin
               cmd.walk_step = 1'b1;
               if (status.walk_last) begin
                  state_in = dlr_pkg::ST_FLUSH;
               end
            end
         end
         dlr_pkg::ST_FLUSH: begin
            if (status.can_push) begin
               cmd.flush = 1'b1;
               state_in  = dlr_pkg::ST_IDLE;
            end
         end
         default: begin
            state_in = dlr_pkg::ST_IDLE;
         end
      endcase
   end

endmodule

// ----- rtl/core/dlr_datapath.sv -----
module dlr_datapath #(
   parameter int IMAGE_SIDE = dlr_pkg::IMAGE_SIDE_DEF
) (
   input  logic                              clock,
   input  logic                              reset,
   input  dlr_pkg::dp_cmd_type               cmd,
   output dlr_pkg::dp_status_type            status,
   input  logic [dlr_pkg::COORD_W-1:0]       req_start_x,
   input  logic [dlr_pkg::COORD_W-1:0]       req_start_y,
   input  logic [dlr_pkg::COORD_W-1:0]       req_end_x,
   input  logic [dlr_pkg::COORD_W-1:0]       req_end_y,
   input  logic [dlr_pkg::GRAY_W-1:0]        req_gray_level,
   input  logic [dlr_pkg::STRIDE_W-1:0]      row_stride,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [dlr_pkg::ADDR_OUT_W-1:0]    rsp_pixel_address,
   output logic [dlr_pkg::GRAY_W-1:0]        rsp_pixel_value,
   output logic                              rsp_last_pixel
);

   localparam int CW = dlr_pkg::COORD_W;
   localparam int PW = dlr_pkg::POS_W;
   localparam logic [31:0] ClipBound = 32'(IMAGE_SIDE * IMAGE_SIDE);

   // line setup
   logic signed [CW:0]   delta_x, delta_y;
   logic [CW-1:0]        abs_x, abs_y;
   logic                 x_major;
   logic [CW+dlr_pkg::STRIDE_W-1:0] base_prod;

   assign delta_x = signed'({1'b0, req_end_x}) - signed'({1'b0, req_start_x});
   assign delta_y = signed'({1'b0, req_end_y}) - signed'({1'b0, req_start_y});
   assign abs_x   = delta_x[CW] ? CW'(-delta_x) : CW'(delta_x);
   assign abs_y   = delta_y[CW] ? CW'(-delta_y) : CW'(delta_y);
   assign x_major = abs_x > abs_y;
   assign base_prod = (CW + dlr_pkg::STRIDE_W)'(req_start_y)
                    * (CW + dlr_pkg::STRIDE_W)'(row_stride);

   logic [CW-1:0]                   amaj_ff, rem_ff, step_cnt_ff;
   logic                            x_major_ff, maj_neg_ff, min_neg_ff;
   logic signed [PW-1:0]            col_ff, base_ff;
   logic [dlr_pkg::GRAY_W-1:0]      gray_ff;
   logic [dlr_pkg::QUO_W-1:0]       quo_ff;
   logic [dlr_pkg::ACC_W-1:0]       acc_ff;
   logic                            pend_valid_ff;
   logic [dlr_pkg::ADDR_OUT_W-1:0]  pend_addr_ff;
   logic                            rsp_valid_ff, rsp_last_ff;
   logic [dlr_pkg::ADDR_OUT_W-1:0]  rsp_addr_ff;
   logic [dlr_pkg::GRAY_W-1:0]      rsp_value_ff;

   // restoring divider, one quotient bit per cycle; first step is unshifted
   logic [CW:0]   div_trial;
   logic          div_ge;
   logic [CW-1:0] div_rem;

   assign div_trial = cmd.div_first ? {1'b0, rem_ff} : {rem_ff, 1'b0};
   assign div_ge    = div_trial >= {1'b0, amaj_ff};
   assign div_rem   = div_ge ? CW'(div_trial - {1'b0, amaj_ff}) : CW'(div_trial);

   // pixel walk
   logic signed [PW-1:0]       addr_cur, stride_s, maj_unit, min_unit, maj_rstep, min_rstep;
   logic signed [PW-1:0]       col_next, base_next;
   logic [dlr_pkg::ACC_W-1:0]  acc_next;
   logic                       minor_move, clipped, push;

   assign addr_cur  = base_ff + col_ff;
   assign clipped   = addr_cur[PW-1] || ({{(32-PW){1'b0}}, addr_cur} >= ClipBound);
   assign acc_next  = acc_ff + dlr_pkg::ACC_W'(quo_ff);
   // slope magnitude is at most 1.0, so the integer part moves by at most one
   assign minor_move = acc_next[dlr_pkg::FRAC_W] ^ acc_ff[dlr_pkg::FRAC_W];
   assign stride_s  = signed'({{(PW-dlr_pkg::STRIDE_W){1'b0}}, row_stride});
   assign maj_unit  = maj_neg_ff ? '1 : PW'(1);
   assign min_unit  = min_neg_ff ? '1 : PW'(1);
   assign maj_rstep = maj_neg_ff ? -stride_s : stride_s;
   assign min_rstep = min_neg_ff ? -stride_s : stride_s;

   always_comb begin
      if (x_major_ff) begin
         col_next  = col_ff + maj_unit;
         base_next = minor_move ? base_ff + min_rstep : base_ff;
      end else begin
         col_next  = minor_move ? col_ff + min_unit : col_ff;
         base_next = base_ff + maj_rstep;
      end
   end

   // a pixel is held back one slot so the last emitted one can be flagged
   assign push = pend_valid_ff && ((cmd.walk_step && !clipped) || cmd.flush);

   assign status.zero_len  = (amaj_ff == '0);
   assign status.walk_last = (step_cnt_ff == CW'(amaj_ff - 1'b1));
   assign status.can_push  = !rsp_valid_ff || rsp_ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         pend_valid_ff <= 1'b0;
         rsp_valid_ff  <= 1'b0;
      end else begin
         if (cmd.load || cmd.flush) begin
            pend_valid_ff <= 1'b0;
         end else if (cmd.walk_step && !clipped) begin
            pend_valid_ff <= 1'b1;
         end
         if (push) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         amaj_ff     <= x_major ? abs_x : abs_y;
         rem_ff      <= x_major ? abs_y : abs_x;
         x_major_ff  <= x_major;
         maj_neg_ff  <= x_major ? delta_x[CW] : delta_y[CW];
         min_neg_ff  <= x_major ? delta_y[CW] : delta_x[CW];
         col_ff      <= signed'(PW'(req_start_x));
         base_ff     <= signed'(PW'(base_prod));
         gray_ff     <= req_gray_level;
         quo_ff      <= '0;
         acc_ff      <= '0;
         step_cnt_ff <= '0;
      end
      if (cmd.div_step) begin
         rem_ff <= div_rem;
         quo_ff <= {quo_ff[dlr_pkg::QUO_W-2:0], div_ge};
      end
      if (cmd.walk_step) begin
         acc_ff      <= acc_next;
         col_ff      <= col_next;
         base_ff     <= base_next;
         step_cnt_ff <= step_cnt_ff + 1'b1;
         if (!clipped) begin
            pend_addr_ff <= addr_cur[dlr_pkg::ADDR_OUT_W-1:0];
         end
      end
      if (push) begin
         rsp_addr_ff  <= pend_addr_ff;
         rsp_value_ff <= gray_ff;
         rsp_last_ff  <= cmd.flush;
      end
   end

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_pixel_address = rsp_addr_ff;
   assign rsp_pixel_value   = rsp_value_ff;
   assign rsp_last_pixel    = rsp_last_ff;

endmodule

// ----- rtl/core/dda_line_rasterizer.sv -----
// Sequence: accept, bit-serial slope divide, then one pixel write per cycle along the major
// axis while the output is not stalled (clipped pixels are skipped), then a flush step.
// A new line is taken only once the current one is done; a zero-length line goes back to
// idle with no walk. The bit-serial slope divider and the single walk unit set this.
// Reset (synchronous, active high) returns the sequencer to idle, drops any queued
// pixel and sets row_stride to 64.
module dda_line_rasterizer #(
   parameter int IMAGE_SIDE = dlr_pkg::IMAGE_SIDE_DEF
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_valid,
   output logic                               req_ready,
   input  logic [dlr_pkg::COORD_W-1:0]        req_start_x,
   input  logic [dlr_pkg::COORD_W-1:0]        req_start_y,
   input  logic [dlr_pkg::COORD_W-1:0]        req_end_x,
   input  logic [dlr_pkg::COORD_W-1:0]        req_end_y,
   input  logic [dlr_pkg::GRAY_W-1:0]         req_gray_level,
   output logic                               rsp_valid,
   input  logic                               rsp_ready,
   output logic [dlr_pkg::ADDR_OUT_W-1:0]     rsp_pixel_address,
   output logic [dlr_pkg::GRAY_W-1:0]         rsp_pixel_value,
   output logic                               rsp_last_pixel,
   input  logic                               csr_psel,
   input  logic                               csr_penable,
   input  logic                               csr_pwrite,
   input  logic [dlr_pkg::CSR_ADDR_W-1:0]     csr_paddr,
   input  logic [dlr_pkg::CSR_DATA_W-1:0]     csr_pwdata,
   output logic [dlr_pkg::CSR_DATA_W-1:0]     csr_prdata,
   output logic                               csr_pready
);

   logic [dlr_pkg::STRIDE_W-1:0] row_stride_ff;
   logic                         csr_hit;

   assign csr_pready = 1'b1;
   assign csr_hit    = csr_paddr[dlr_pkg::CSR_ADDR_W-1] == dlr_pkg::CSR_ROW_STRIDE;

   always_ff @(posedge clock) begin
      if (reset) begin
         row_stride_ff <= dlr_pkg::STRIDE_RESET;
      end else if (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_hit) begin
         row_stride_ff <= csr_pwdata[dlr_pkg::STRIDE_W-1:0];
      end
   end

   assign csr_prdata = csr_hit ? dlr_pkg::CSR_DATA_W'(row_stride_ff) : '0;

   dlr_pkg::dp_cmd_type    cmd;
   dlr_pkg::dp_status_type status;

   dlr_controller u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_ready (req_ready),
      .status    (status),
      .cmd       (cmd)
   );

   dlr_datapath #(
      .IMAGE_SIDE (IMAGE_SIDE)
   ) u_dp (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_start_x       (req_start_x),
      .req_start_y       (req_start_y),
      .req_end_x         (req_end_x),
      .req_end_y         (req_end_y),
      .req_gray_level    (req_gray_level),
      .row_stride        (row_stride_ff),
      .rsp_valid         (rsp_valid),
      .rsp_ready         (rsp_ready),
      .rsp_pixel_address (rsp_pixel_address),
      .rsp_pixel_value   (rsp_pixel_value),
      .rsp_last_pixel    (rsp_last_pixel)
   );

endmodule

// ----- rtl/core/dlr_checker.sv -----
`include "dda_line_rasterizer_defines.svh"

module dlr_checker (
   input logic                            clock,
   input logic                            reset,
   input logic                            req_valid,
   input logic                            req_ready,
   input logic                            rsp_valid,
   input logic                            rsp_ready,
   input logic [dlr_pkg::ADDR_OUT_W-1:0]  rsp_pixel_address,
   input logic [dlr_pkg::GRAY_W-1:0]      rsp_pixel_value,
   input logic                            rsp_last_pixel,
   input logic                            csr_psel,
   input logic                            csr_penable,
   input logic                            csr_pwrite,
   input logic [dlr_pkg::CSR_ADDR_W-1:0]  csr_paddr,
   input logic [dlr_pkg::CSR_DATA_W-1:0]  csr_pwdata,
   input logic [dlr_pkg::CSR_DATA_W-1:0]  csr_prdata,
   input logic                            csr_pready
);

   `DLR_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_pixel_address) && $stable(rsp_pixel_value) && $stable(rsp_last_pixel), "stalled pixel transaction changed")

   // one line at a time: no new command right after one is taken
   `DLR_ASSERT_NEXT(a_one_line, clock, reset, req_valid && req_ready, !req_ready, "command taken while a line is in flight")

   `DLR_ASSERT_NEXT(a_reset_idle, clock, 1'b0, reset, !rsp_valid && req_ready, "block not idle after reset")

   `DLR_ASSERT_SAME(a_stride_rb, clock, reset, (csr_psel && csr_penable && csr_pwrite && csr_pready && csr_paddr[dlr_pkg::CSR_ADDR_W-1] == dlr_pkg::CSR_ROW_STRIDE) ##1 (csr_psel && !csr_pwrite && csr_paddr[dlr_pkg::CSR_ADDR_W-1] == dlr_pkg::CSR_ROW_STRIDE), csr_prdata[dlr_pkg::STRIDE_W-1:0] == $past(csr_pwdata[dlr_pkg::STRIDE_W-1:0]), "row_stride readback mismatch")

endmodule

bind dda_line_rasterizer dlr_checker u_chk (.*);
